### rtl/packed_nibble_line_rasterizer_defines.svh
// assertion macros for the rasterizer rtl
`ifndef PACKED_NIBBLE_LINE_RASTERIZER_DEFINES_SVH
`define PACKED_NIBBLE_LINE_RASTERIZER_DEFINES_SVH

// condition must hold in the same cycle
`define PNLR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pnlr same-cycle check failed");

// condition must hold in the next cycle
`define PNLR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pnlr next-cycle check failed");

`endif

### rtl/pnlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pnlr_pkg;

   localparam int CMD_BITS       = 2;
   localparam int COLOR_BITS     = 8;
   localparam int PIXEL_BITS     = 4;
   localparam int DATA_BITS      = 8;
   localparam int READ_ADDR_BITS = 13;

   localparam logic [DATA_BITS-1:0]  NIBBLE_LO_MASK = 8'h0f;
   localparam logic [DATA_BITS-1:0]  NIBBLE_HI_MASK = 8'hf0;
   localparam logic [PIXEL_BITS-1:0] COLOR_MAX      = 4'hf;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_PLOT  = 2'd0,
      CMD_LINE  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_BYTE_RD
   } state_type;

   // walker controls from the sequencer
   typedef struct packed {
      logic load;
      logic step;
   } walk_ctrl_type;

endpackage

`default_nettype wire

### rtl/pnlr_store.sv
`timescale 1ns / 1ps
`default_nettype none

module pnlr_store import pnlr_pkg::*; #(
   parameter int DEPTH = 8192,
   parameter int AW    = 13
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AW-1:0]        waddr,
   input  wire logic [DATA_BITS-1:0] wdata,
   input  wire logic                 re,
   input  wire logic [AW-1:0]        raddr,
   output logic      [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/pnlr_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module pnlr_walker import pnlr_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire walk_ctrl_type                walk_ctrl,
   input  wire logic signed [COORD_BITS-1:0] ld_x_start,
   input  wire logic signed [COORD_BITS-1:0] ld_y_start,
   input  wire logic signed [COORD_BITS-1:0] ld_x_end,
   input  wire logic signed [COORD_BITS-1:0] ld_y_end,
   output logic signed      [COORD_BITS-1:0] walk_x,
   output logic signed      [COORD_BITS-1:0] walk_y,
   output logic                              walk_at_end
);

   localparam int DW = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 3;

   logic signed [COORD_BITS-1:0] walk_x_ff, walk_x_in;
   logic signed [COORD_BITS-1:0] walk_y_ff, walk_y_in;
   logic signed [EW-1:0]         err_ff, err_in;
   logic signed [COORD_BITS-1:0] x_end_ff, y_end_ff;
   logic signed [DW-1:0]         dx_ff, dy_ff, dx_in, dy_in;
   logic                         sx_neg_ff, sy_neg_ff;
   logic signed [EW:0]           e2;
   logic                         go_x, go_y;

   // absolute deltas of the new line
   always_comb begin
      if (ld_x_end > ld_x_start) begin
         dx_in = DW'(ld_x_end) - DW'(ld_x_start);
      end else begin
         dx_in = DW'(ld_x_start) - DW'(ld_x_end);
      end
      if (ld_y_end > ld_y_start) begin
         dy_in = DW'(ld_y_end) - DW'(ld_y_start);
      end else begin
         dy_in = DW'(ld_y_start) - DW'(ld_y_end);
      end
   end

   assign e2   = $signed({err_ff, 1'b0});
   assign go_x = e2 > -((EW+1)'(dy_ff));
   assign go_y = e2 < (EW+1)'(dx_ff);

   always_comb begin
      walk_x_in = walk_x_ff;
      walk_y_in = walk_y_ff;
      err_in    = err_ff;
      if (walk_ctrl.load) begin
         walk_x_in = ld_x_start;
         walk_y_in = ld_y_start;
         err_in    = EW'(dx_in) - EW'(dy_in);
      end else if (walk_ctrl.step) begin
         err_in = err_ff - (go_x ? EW'(dy_ff) : EW'(0)) + (go_y ? EW'(dx_ff) : EW'(0));
         if (go_x) begin
            walk_x_in = walk_x_ff + (sx_neg_ff ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
         end
         if (go_y) begin
            walk_y_in = walk_y_ff + (sy_neg_ff ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_x_ff <= '0;
         walk_y_ff <= '0;
         err_ff    <= '0;
      end else begin
         walk_x_ff <= walk_x_in;
         walk_y_ff <= walk_y_in;
         err_ff    <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (walk_ctrl.load) begin
         x_end_ff  <= ld_x_end;
         y_end_ff  <= ld_y_end;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         sx_neg_ff <= !(ld_x_start < ld_x_end);
         sy_neg_ff <= !(ld_y_start < ld_y_end);
      end
   end

   assign walk_x      = walk_x_ff;
   assign walk_y      = walk_y_ff;
   assign walk_at_end = (walk_x_ff == x_end_ff) && (walk_y_ff == y_end_ff);

endmodule

`default_nettype wire

### rtl/packed_nibble_line_rasterizer.sv
// sequence: a plot and each line point pass ST_PIX_RD then ST_PIX_WR, a read passes
//   ST_BYTE_RD, a clear sweeps ST_CLEAR over all store_bytes; the strobe is registered
// throughput: one command at a time; each pixel is a read-modify-write of
//   one byte on the simple dual-port frame memory, which sets the line rate
// reset: synchronous; busy stays high while the memory is
//   swept to zero, one byte a cycle; the result strobe cannot be stalled
`timescale 1ns / 1ps
`default_nettype none

module packed_nibble_line_rasterizer import pnlr_pkg::*; #(
   parameter int SCREEN_WIDTH  = 256,
   parameter int SCREEN_HEIGHT = 64,
   parameter int COORD_BITS    = 12
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [CMD_BITS-1:0]          req_cmd,
   input  wire logic signed [COORD_BITS-1:0] req_x_start,
   input  wire logic signed [COORD_BITS-1:0] req_y_start,
   input  wire logic signed [COORD_BITS-1:0] req_x_end,
   input  wire logic signed [COORD_BITS-1:0] req_y_end,
   input  wire logic [COLOR_BITS-1:0]        req_color,
   input  wire logic [READ_ADDR_BITS-1:0]    req_read_address,
   output logic                              rsp_strobe,
   output logic [DATA_BITS-1:0]              rsp_read_data
);

`include "packed_nibble_line_rasterizer_defines.svh"

   // rows never share a byte, odd widths round up
   localparam int ROW_BYTES   = (SCREEN_WIDTH + 1) / 2;
   localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
   localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   // sequencer state
   state_type                    state_ff, state_in;
   cmd_type                      cmd_ff, cmd_in;
   logic signed [COORD_BITS-1:0] pt_x_ff, pt_x_in;
   logic signed [COORD_BITS-1:0] pt_y_ff, pt_y_in;
   logic [PIXEL_BITS-1:0]        color_ff, color_in;
   logic                         walking_ff, walking_in;
   logic                         rd_ok_ff, rd_ok_in;
   logic [AW-1:0]                wr_addr_ff, wr_addr_in;
   logic                         wr_odd_ff, wr_odd_in;
   logic                         wr_ok_ff, wr_ok_in;
   logic [AW-1:0]                clr_cnt_ff, clr_cnt_in;
   logic                         clr_rsp_ff, clr_rsp_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_BITS-1:0]         rsp_data_ff, rsp_data_in;

   // memory port
   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [DATA_BITS-1:0] mem_wdata, mem_rdata;

   // walker
   walk_ctrl_type                walk_ctrl;
   logic signed [COORD_BITS-1:0] walk_x, walk_y;
   logic                         walk_at_end;

   // pixel address path
   logic signed [COORD_BITS-1:0] plot_x, plot_y;
   logic [COORD_BITS-1:0]        plot_xu, plot_yu;
   logic                         pix_ok;
   logic [AW-1:0]                pix_addr;
   logic                         rd_in_range;
   logic [PIXEL_BITS-1:0]        color_sat;
   logic [DATA_BITS-1:0]         merged;

   pnlr_store #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   pnlr_walker #(
      .COORD_BITS (COORD_BITS)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .walk_ctrl   (walk_ctrl),
      .ld_x_start  (req_x_start),
      .ld_y_start  (req_y_start),
      .ld_x_end    (req_x_end),
      .ld_y_end    (req_y_end),
      .walk_x      (walk_x),
      .walk_y      (walk_y),
      .walk_at_end (walk_at_end)
   );

   // the first point of a line is its end point, later ones come from the walker
   assign plot_x  = walking_ff ? walk_x : pt_x_ff;
   assign plot_y  = walking_ff ? walk_y : pt_y_ff;
   assign plot_xu = $unsigned(plot_x);
   assign plot_yu = $unsigned(plot_y);

   // off-screen points, negative ones included, are dropped
   assign pix_ok = !plot_x[COORD_BITS-1] && !plot_y[COORD_BITS-1]
                   && (32'(plot_xu) < SCREEN_WIDTH) && (32'(plot_yu) < SCREEN_HEIGHT);

   // byte index: y * row bytes + x / 2
   assign pix_addr = AW'(32'(plot_yu) * ROW_BYTES + 32'(plot_xu >> 1));

   assign rd_in_range = 32'(req_read_address) < STORE_BYTES;

   // colors above the nibble range saturate
   assign color_sat = (req_color > COLOR_BITS'(COLOR_MAX)) ? COLOR_MAX
                                                           : req_color[PIXEL_BITS-1:0];

   // even x in the high nibble, odd x in the low nibble
   assign merged = wr_odd_ff ? ((mem_rdata & NIBBLE_HI_MASK) | {4'h0, color_ff})
                             : ((mem_rdata & NIBBLE_LO_MASK) | {color_ff, 4'h0});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         walking_ff    <= 1'b0;
         clr_cnt_ff    <= '0;
         clr_rsp_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walking_ff    <= walking_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_rsp_ff    <= clr_rsp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // transaction payload, no reset needed
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      color_ff    <= color_in;
      rd_ok_ff    <= rd_ok_in;
      wr_addr_ff  <= wr_addr_in;
      wr_odd_ff   <= wr_odd_in;
      wr_ok_ff    <= wr_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pt_x_in       = pt_x_ff;
      pt_y_in       = pt_y_ff;
      color_in      = color_ff;
      walking_in    = walking_ff;
      rd_ok_in      = rd_ok_ff;
      wr_addr_in    = wr_addr_ff;
      wr_odd_in     = wr_odd_ff;
      wr_ok_in      = wr_ok_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = wr_addr_ff;
      mem_wdata     = merged;
      mem_re        = 1'b0;
      mem_raddr     = pix_addr;
      walk_ctrl     = '0;

      unique case (state_ff)
         // sweep zeros through the memory, after reset or on a clear command
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(STORE_BYTES - 1)) begin
               state_in      = ST_IDLE;
               clr_cnt_in    = '0;
               clr_rsp_in    = 1'b0;
               rsp_strobe_in = clr_rsp_ff;
               rsp_data_in   = '0;
            end
         end

         ST_IDLE: begin
            if (start) begin
               cmd_in     = cmd_type'(req_cmd);
               color_in   = color_sat;
               walking_in = 1'b0;
               unique case (cmd_type'(req_cmd))
                  CMD_PLOT: begin
                     pt_x_in  = req_x_start;
                     pt_y_in  = req_y_start;
                     state_in = ST_PIX_RD;
                  end
                  CMD_LINE: begin
                     // end point goes first, walker starts at the start point
                     pt_x_in        = req_x_end;
                     pt_y_in        = req_y_end;
                     walk_ctrl.load = 1'b1;
                     state_in       = ST_PIX_RD;
                  end
                  CMD_READ: begin
                     mem_re    = rd_in_range;
                     mem_raddr = AW'(req_read_address);
                     rd_ok_in  = rd_in_range;
                     state_in  = ST_BYTE_RD;
                  end
                  CMD_CLEAR: begin
                     clr_cnt_in = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
               endcase
            end
         end

         // read the byte holding the pixel, advance the walk behind it
         ST_PIX_RD: begin
            mem_re         = pix_ok;
            mem_raddr      = pix_addr;
            wr_addr_in     = pix_addr;
            wr_odd_in      = plot_xu[0];
            wr_ok_in       = pix_ok;
            walk_ctrl.step = walking_ff;
            state_in       = ST_PIX_WR;
         end

         // merge the nibble and write back, then next point or finish
         ST_PIX_WR: begin
            mem_we    = wr_ok_ff;
            mem_waddr = wr_addr_ff;
            mem_wdata = merged;
            if ((cmd_ff == CMD_LINE) && !walk_at_end) begin
               walking_in = 1'b1;
               state_in   = ST_PIX_RD;
            end else begin
               walking_in    = 1'b0;
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '0;
               state_in      = ST_IDLE;
            end
         end

         // read data is out of the memory register now
         ST_BYTE_RD: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = rd_ok_ff ? mem_rdata : '0;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_data = rsp_data_ff;

   // no memory write while waiting for a command
   `PNLR_ASSERT_SAME(a_idle_no_write, clock, reset, state_ff == ST_IDLE, !mem_we)
   // an accepted transaction makes the block busy
   `PNLR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // only a read returns nonzero data
   `PNLR_ASSERT_SAME(a_data_read_only, clock, reset, rsp_strobe && |rsp_read_data, cmd_ff == CMD_READ)
   // the walker steps only while walking a line
   `PNLR_ASSERT_SAME(a_step_line_only, clock, reset, walk_ctrl.step, walking_ff && (cmd_ff == CMD_LINE))

endmodule

`default_nettype wire
